/* rtl/core/tdp_pkg.sv */
// Shared widths, types and constants for the trial-division prime test.
package tdp_pkg;

  // Candidate width in bits (two's complement)
  localparam int DATA_WIDTH = 32;
  // Trial divisor width: covers sqrt(2^(DATA_WIDTH-1)) + 1
  localparam int DIV_W      = DATA_WIDTH / 2 + 1;
  // Width of the running divisor square
  localparam int SQ_W       = 2 * DIV_W;
  // Bit counter width for the serial remainder
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic signed [DATA_WIDTH-1:0] cand_t;
  typedef logic [DATA_WIDTH-1:0]        mag_t;
  typedef logic [DIV_W-1:0]             div_t;
  typedef logic [SQ_W-1:0]              sq_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  // Smallest prime, first trial divisor and its square
  localparam mag_t CAND_TWO  = mag_t'(2);
  localparam div_t DIV_FIRST = div_t'(2);
  localparam sq_t  SQ_FIRST  = sq_t'(4);
  // Magnitude bits shifted through the remainder per divisor
  localparam cnt_t BIT_COUNT = cnt_t'(DATA_WIDTH - 1);

endpackage

/* rtl/core/tdp_if.sv */
// Valid/ready channel interfaces for candidates and prime answers.
interface tdp_in_if;
  import tdp_pkg::*;

  logic  valid;
  logic  ready;
  cand_t candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_out_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

/* rtl/core/trial_division_prime_test.sv */
// Trial-division primality test with a bit-serial remainder unit.
//
//   channel  dir  payload                         transaction when
//   in_if    in   candidate [DATA_WIDTH-1:0] s    valid && ready
//   out_if   out  is_prime  [0:0]                 valid && ready
//
// Negatives, 0 and 1 skip the divisor search and go straight to delivery.
// Otherwise each trial divisor d = 2, 3, ... takes a square check and then a
// remainder over the DATA_WIDTH-1 magnitude bits (one candidate bit per cycle),
// until d*d exceeds the candidate or a remainder is zero. One candidate is
// worked on at a time; in_if.ready is high while idle, also while a finished
// answer still waits in the output register.
// Reset (synchronous, rst_n low) empties the output register and idles.
module trial_division_prime_test (
  input logic          clk,
  input logic          rst_n,
  tdp_in_if.sink       in_if,
  tdp_out_if.source    out_if
);
  import tdp_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state_r, state_nxt;
  mag_t       v_r, v_nxt;
  mag_t       sh_r, sh_nxt;
  div_t       d_r, d_nxt;
  div_t       rem_r, rem_nxt;
  sq_t        sq_r, sq_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic       res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_is_prime_r, out_is_prime_nxt;

  logic             in_fire;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  div_t             rem_step;

  assign in_if.ready     = (state_r == ST_IDLE);
  assign in_fire         = in_if.valid && in_if.ready;
  assign out_if.valid    = out_valid_r;
  assign out_if.is_prime = out_is_prime_r;

  // Restoring division step: shift in one candidate bit, subtract if it fits
  always_comb begin
    trial    = {rem_r, sh_r[DATA_WIDTH-1]};
    diff     = trial - {1'b0, d_r};
    rem_step = diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
  end

  // Sequencer: screen, square check, serial remainder, deliver
  always_comb begin
    state_nxt        = state_r;
    v_nxt            = v_r;
    sh_nxt           = sh_r;
    d_nxt            = d_r;
    rem_nxt          = rem_r;
    sq_nxt           = sq_r;
    cnt_nxt          = cnt_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r;
    out_is_prime_nxt = out_is_prime_r;

    // Drop the answer once the sink takes it
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          v_nxt = mag_t'(in_if.candidate);
          d_nxt = DIV_FIRST;
          sq_nxt = SQ_FIRST;
          if (in_if.candidate[DATA_WIDTH-1] || (mag_t'(in_if.candidate) < CAND_TWO)) begin
            res_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_r > sq_t'(v_r)) begin
          res_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          rem_nxt   = '0;
          sh_nxt    = v_r << 1;
          cnt_nxt   = BIT_COUNT;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_step;
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r - cnt_t'(1);
        if (cnt_r == cnt_t'(1)) begin
          if (rem_step == '0) begin
            res_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            // Advance to the next divisor: (d+1)^2 = d^2 + 2d + 1
            d_nxt     = d_r + div_t'(1);
            sq_nxt    = sq_r + sq_t'({d_r, 1'b0}) + sq_t'(1);
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = res_r;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    v_r            <= v_nxt;
    sh_r           <= sh_nxt;
    d_r            <= d_nxt;
    rem_r          <= rem_nxt;
    sq_r           <= sq_nxt;
    cnt_r          <= cnt_nxt;
    res_r          <= res_nxt;
    out_is_prime_r <= out_is_prime_nxt;
  end

  // A negative candidate goes straight to delivery with a not-prime answer
  a_neg_screen: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_if.candidate[DATA_WIDTH-1] |=> (state_r == ST_FIN) && !res_r)
    else $error("negative candidate not screened");

  // The partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < d_r))
    else $error("remainder out of range");

  // The running square tracks the divisor
  a_square: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (sq_r == sq_t'(d_r) * sq_t'(d_r)))
    else $error("divisor square out of step");

  // A prime answer is only given after the divisor square passed the candidate
  a_prime_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) && (state_nxt == ST_FIN) |-> (sq_r > sq_t'(v_r)))
    else $error("prime answer without finished search");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench: directed and random candidates against a trial-division predictor.
module tb_top;
  import tdp_pkg::*;

  localparam int HALF_PERIOD      = 4;
  localparam int RESET_CYCLES     = 4;
  localparam int RANDOM_PER_PHASE = 25;
  localparam int BURST_ITEMS      = 6;
  localparam int HOLD_OFF_CYCLES  = 600;
  localparam int DRAIN_CYCLES     = 64;
  // Slowest item here is a 24-bit prime, searched over about 4096 divisors
  localparam int STALL_LIMIT      = 500_000;

  typedef struct packed {
    cand_t candidate;
    logic  known;
    logic  is_prime;
  } probe_t;

  typedef struct {
    cand_t candidate;
    logic  is_prime;
  } answer_t;

  // Directed candidates; the answer is typed in only where it is obvious.
  // The top of the positive range is a prime whose full search would dwarf the
  // whole run, so its even neighbour stands in for it.
  localparam int N_PROBES = 20;
  localparam probe_t PROBES [N_PROBES] = '{
    '{cand_t'(32'h8000_0000), 1'b1, 1'b0},  // most negative
    '{cand_t'(32'hFFFF_FFFF), 1'b1, 1'b0},  // minus one
    '{cand_t'(32'd0),         1'b1, 1'b0},  // zero
    '{cand_t'(32'd1),         1'b1, 1'b0},  // one
    '{cand_t'(32'd2),         1'b1, 1'b1},  // two: no divisor tried
    '{cand_t'(32'd3),         1'b1, 1'b1},  // three: no divisor tried
    '{cand_t'(32'h7FFF_FFFE), 1'b1, 1'b0},  // largest even value
    '{cand_t'(32'd4),         1'b0, 1'b0},  // square of the first divisor
    '{cand_t'(32'd5),         1'b0, 1'b0},
    '{cand_t'(32'd9),         1'b0, 1'b0},
    '{cand_t'(32'd15),        1'b0, 1'b0},
    '{cand_t'(32'd25),        1'b0, 1'b0},
    '{cand_t'(32'd49),        1'b0, 1'b0},
    '{cand_t'(32'd91),        1'b0, 1'b0},
    '{cand_t'(32'h7FFF_FFFD), 1'b0, 1'b0},
    '{cand_t'(32'h5555_5555), 1'b0, 1'b0},
    '{cand_t'(32'h2AAA_AAAA), 1'b0, 1'b0},
    '{cand_t'(32'd65521),     1'b0, 1'b0},
    '{cand_t'(32'd65537),     1'b0, 1'b0},
    '{cand_t'(32'd16777213),  1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  tdp_in_if  in_if ();
  tdp_out_if out_if ();

  trial_division_prime_test dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  answer_t pending_answers[$];
  int      mismatches      = 0;
  int      candidates_sent = 0;
  int      primes_seen     = 0;
  int      others_seen     = 0;
  int      quiet_cycles    = 0;
  int      tx_idle_pct     = 20;
  int      rx_idle_pct     = 84;
  bit      hold_off_req    = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  // Work out the answer by trying divisors until the square passes the candidate
  function automatic logic prime_by_division(cand_t c);
    mag_t            v;
    longint unsigned d;
    v = mag_t'(c);
    if (c[DATA_WIDTH-1]) return 1'b0;
    if (v < CAND_TWO) return 1'b0;
    for (d = 2; d * d <= v; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Small values most often, also medium ones, negatives and large composites
  function automatic cand_t random_candidate();
    int unsigned pick;
    int unsigned factor;
    pick = $urandom_range(99);
    if (pick < 40) return cand_t'($urandom_range(4096));
    if (pick < 55) return cand_t'($urandom_range(1 << 20));
    if (pick < 75) return cand_t'($urandom() | 32'h8000_0000);
    // Large value with a factor of at most 13 keeps the search short
    factor = $urandom_range(2, 13);
    return cand_t'(factor * $urandom_range(1, 32'h7FFF_FFFF / factor));
  endfunction

  // Offer one candidate after a random gap and hold it until the transaction
  task automatic offer_candidate(input cand_t c, input logic known, input logic typed_answer);
    answer_t want;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.candidate <= c;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    want.candidate = c;
    want.is_prime  = known ? typed_answer : prime_by_division(c);
    pending_answers.push_back(want);
    candidates_sent++;
  endtask

  // Drive the answer side: random stalls, or a long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check each answer transaction against the oldest expectation; watch for a hang
  always @(posedge clk) begin
    answer_t want;
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_if.valid && out_if.ready) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: answer with nothing expected: got is_prime=%0b",
                   $time, out_if.is_prime);
          mismatches++;
        end else begin
          want = pending_answers.pop_front();
          if (out_if.is_prime !== want.is_prime) begin
            $display("%0t: candidate %0d: expected is_prime=%0b, got %0b",
                     $time, want.candidate, want.is_prime, out_if.is_prime);
            mismatches++;
          end else if (want.is_prime) begin
            primes_seen++;
          end else begin
            others_seen++;
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d answers outstanding",
                 $time, quiet_cycles, pending_answers.size());
        $display("[trial_division_prime_test] ERROR");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed table, then random candidates under three idle patterns
  initial begin
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.candidate <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (PROBES[i]) begin
      offer_candidate(PROBES[i].candidate, PROBES[i].known, PROBES[i].is_prime);
    end
    for (int i = 0; i < RANDOM_PER_PHASE; i++) offer_candidate(random_candidate(), 1'b0, 1'b0);

    // Swap the idle rates
    tx_idle_pct = 84;
    rx_idle_pct = 20;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) offer_candidate(random_candidate(), 1'b0, 1'b0);

    // No idling; hold the answer side off so the block fills and stalls its input
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_off_req = 1'b1;
    for (int i = 0; i < BURST_ITEMS; i++) begin
      offer_candidate(cand_t'($urandom_range(200)), 1'b0, 1'b0);
    end
    for (int i = 0; i < RANDOM_PER_PHASE; i++) offer_candidate(random_candidate(), 1'b0, 1'b0);
    in_if.valid <= 1'b0;

    // Drain outstanding answers, then allow time for any stray one
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Tested %0d candidates: %0d answered prime, %0d not prime, %0d mismatches.",
             candidates_sent, primes_seen, others_seen, mismatches);
    $display("Covered sign and range extremes, small squares, large composites, stalls.");
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("[trial_division_prime_test] OK");
    end else begin
      $display("[trial_division_prime_test] ERROR");
    end
    $finish;
  end

endmodule
